/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the WAVE stream parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* hdl/wsp_pkg.sv */
// ----------------------------------------------------------------------------
// wsp_pkg
// Types and constants shared by the WAVE stream parser modules.
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int POS_W = 33;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] ENC_PCM   = 16'd1;
  localparam logic [15:0] ENC_FLOAT = 16'd3;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TOO_LARGE = 4'd1;
  localparam logic [3:0] ST_MALFORMED = 4'd2;
  localparam logic [3:0] ST_NOT_WAVE  = 4'd3;
  localparam logic [3:0] ST_CHANNELS  = 4'd4;
  localparam logic [3:0] ST_RATE      = 4'd5;
  localparam logic [3:0] ST_ENCODING  = 4'd6;
  localparam logic [3:0] ST_FRAMES    = 4'd7;
  localparam logic [3:0] ST_DECODED   = 4'd8;

  localparam logic [2:0] CFG_MAX_SRC    = 3'd0;
  localparam logic [2:0] CFG_MAX_CH     = 3'd1;
  localparam logic [2:0] CFG_MIN_RATE   = 3'd2;
  localparam logic [2:0] CFG_MAX_RATE   = 3'd3;
  localparam logic [2:0] CFG_MAX_FRAMES = 3'd4;
  localparam logic [2:0] CFG_MAX_DEC    = 3'd5;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SIZE, PH_FMT,
    PH_DATA, PH_SKIP, PH_PAD, PH_DONE, PH_CHECK
  } phase_t;

  typedef enum logic [2:0] {
    CK_LIMITS, CK_RATE, CK_DIV, CK_FRAMES, CK_BUDGET
  } chk_t;

  typedef enum logic [2:0] {
    SK_U8, SK_S16, SK_S24, SK_S32, SK_F32
  } smp_kind_t;

  typedef struct packed {
    logic [31:0] max_src;
    logic [15:0] max_ch;
    logic [31:0] min_rate;
    logic [31:0] max_rate;
    logic [31:0] max_frames;
    logic [34:0] max_dec;
  } cfg_t;

  typedef struct packed {
    logic        is_status;
    smp_kind_t   kind;
    logic [31:0] data;
    logic [3:0]  code;
  } q_entry_t;

endpackage

/* hdl/wave_stream_parser_pcm_to_float.sv */
// ----------------------------------------------------------------------------
// wave_stream_parser_pcm_to_float
// RIFF/WAVE byte stream parser that emits samples as float32 and a status.
// ----------------------------------------------------------------------------
// A file is pushed in one byte per transfer, with end_of_file set on its last
// byte. A byte is accepted whenever push is high and full is low. When the
// header of the first data chunk completes, the parser stops taking bytes
// while it checks the format: a limits step, a byte-rate multiply, a 32-step
// serial division of the chunk size by the block alignment, a frame count step
// with the sample count multiply and a decoded-budget compare. After the last
// byte of each file the input pauses while the status transfer is queued and
// the parse state is cleared; the pause is longer while a format check is
// still running or the queue is full. Samples reach the output ports through
// a four-entry queue and a two-stage float conversion: the stage one register
// and the output register. The output side may stall without losing anything:
// once the queue fills, the input is held off. Each file ends in exactly one
// status transfer, after any samples, carrying the first error found (or zero
// with the frame count). The limit registers should only be written while the
// block is idle.

`include "assert_macros.svh"

module wave_stream_parser_pcm_to_float (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  file_byte,
  input  logic        end_of_file,
  output logic        empty,
  input  logic        pop,
  output logic        is_status,
  output logic [31:0] sample_bits,
  output logic [3:0]  status_code,
  output logic [31:0] frame_total,
  output logic        final_item,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [34:0] cfg_data
);

  wsp_pkg::cfg_t     cfg;
  wsp_pkg::q_entry_t q_wdata, q_rdata;
  logic              q_push, q_full, q_pop, q_empty;
  logic              status_failed;

  // Limit registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_src    <= 32'd16777216;
      cfg.max_ch     <= 16'd2;
      cfg.min_rate   <= 32'd8000;
      cfg.max_rate   <= 32'd192000;
      cfg.max_frames <= 32'd4194304;
      cfg.max_dec    <= 35'd33554432;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wsp_pkg::CFG_MAX_SRC:    cfg.max_src    <= cfg_data[31:0];
        wsp_pkg::CFG_MAX_CH:     cfg.max_ch     <= cfg_data[15:0];
        wsp_pkg::CFG_MIN_RATE:   cfg.min_rate   <= cfg_data[31:0];
        wsp_pkg::CFG_MAX_RATE:   cfg.max_rate   <= cfg_data[31:0];
        wsp_pkg::CFG_MAX_FRAMES: cfg.max_frames <= cfg_data[31:0];
        wsp_pkg::CFG_MAX_DEC:    cfg.max_dec    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end parses bytes and queues raw samples and the final status.
  wsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .full        (full),
    .file_byte   (file_byte),
    .end_of_file (end_of_file),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_wdata)
  );

  wsp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wdata),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  // The back end converts samples to float32 and holds the output transfer.
  wsp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_data      (q_rdata),
    .empty       (empty),
    .pop         (pop),
    .is_status   (is_status),
    .sample_bits (sample_bits),
    .status_code (status_code),
    .frame_total (frame_total),
    .final_item  (final_item)
  );

  assign status_failed = !empty && is_status && (status_code != wsp_pkg::ST_OK);

  // The front end must never write into a full queue.
  `ASSERT_PROP(a_no_overflow, clk, rst, q_push |-> !q_full)
  // After the last byte of a file the input pauses while the status is queued.
  `ASSERT_NEXT(a_eof_pause, clk, rst, push && !full && end_of_file, full)
  // A failed file never reports a frame count.
  `ASSERT_PROP(a_err_no_frames, clk, rst, status_failed |-> (frame_total == 32'd0))

endmodule

/* hdl/wsp_queue.sv */
// ----------------------------------------------------------------------------
// wsp_queue
// Short FIFO between the parsing front end and the sample converter.
// ----------------------------------------------------------------------------
module wsp_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  wsp_pkg::q_entry_t wr_data,
  output logic              full,
  input  logic              rd,
  output wsp_pkg::q_entry_t rd_data,
  output logic              empty
);

  wsp_pkg::q_entry_t             mem [wsp_pkg::Q_DEPTH];
  logic [wsp_pkg::Q_AW-1:0]      wr_ptr;
  logic [wsp_pkg::Q_AW-1:0]      rd_ptr;
  logic [wsp_pkg::Q_AW:0]        count;
  logic                          do_wr;
  logic                          do_rd;

  assign full    = (count == (wsp_pkg::Q_AW+1)'(wsp_pkg::Q_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/wsp_front.sv */
// ----------------------------------------------------------------------------
// wsp_front
// Byte parser: tags, chunk walk, format capture and checks, sample gather.
// ----------------------------------------------------------------------------
module wsp_front (
  input  logic              clk,
  input  logic              rst,
  input  wsp_pkg::cfg_t     cfg,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        file_byte,
  input  logic              end_of_file,
  input  logic              q_full,
  output logic              q_push,
  output wsp_pkg::q_entry_t q_data
);

  wsp_pkg::phase_t phase, phase_next;
  wsp_pkg::chk_t   chk, chk_next;

  logic [wsp_pkg::POS_W-1:0] pos, pos_next, newpos;
  logic [31:0]  rem, rem_next, rem_dec;
  logic [31:0]  tag, tag_next, hdr_word;
  logic [31:0]  riff, riff_next;
  logic [127:0] raw, raw_next;
  logic [1:0]   seen, seen_next;
  logic [31:0]  gather, gather_next, gather_new;
  logic [1:0]   sbi, sbi_next;
  logic [3:0]   err, err_next;
  logic [31:0]  frames, frames_next;
  logic [31:0]  chunk_id, chunk_id_next;
  logic         pad, pad_next;
  logic [4:0]   fmt_cnt, fmt_cnt_next;
  logic         eof_pend, eof_pend_next;
  logic [17:0]  align_r, align_next;
  logic [31:0]  div_q, div_q_next;
  logic [17:0]  div_r, div_r_next;
  logic [4:0]   div_cnt, div_cnt_next;
  logic [47:0]  samp_r, samp_next;

  logic [15:0]  f_enc, f_ch, f_align, f_bits;
  logic [31:0]  f_rate, f_brate;
  logic [2:0]   bps;
  logic [1:0]   last_idx;
  logic         enc_ok;
  logic         acc, too_big, hdr_done, smp_done, status_go;
  logic [31:0]  prod_lo;
  logic [18:0]  trial;
  logic         trial_ge;
  logic [3:0]   fin_code;
  wsp_pkg::smp_kind_t kind;

  assign f_enc   = raw[15:0];
  assign f_ch    = raw[31:16];
  assign f_rate  = raw[63:32];
  assign f_brate = raw[95:64];
  assign f_align = raw[111:96];
  assign f_bits  = raw[127:112];

  assign bps      = f_bits[5:3];
  assign last_idx = bps[1:0] - 2'd1;
  assign enc_ok   = ((f_enc == wsp_pkg::ENC_PCM) &&
                     (f_bits == 16'd8 || f_bits == 16'd16 ||
                      f_bits == 16'd24 || f_bits == 16'd32)) ||
                    ((f_enc == wsp_pkg::ENC_FLOAT) && (f_bits == 16'd32));

  always_comb begin
    if (f_enc == wsp_pkg::ENC_FLOAT) begin
      kind = wsp_pkg::SK_F32;
    end else begin
      case (f_bits)
        16'd8:   kind = wsp_pkg::SK_U8;
        16'd16:  kind = wsp_pkg::SK_S16;
        16'd24:  kind = wsp_pkg::SK_S24;
        default: kind = wsp_pkg::SK_S32;
      endcase
    end
  end

  assign full      = q_full || eof_pend || (phase == wsp_pkg::PH_CHECK);
  assign acc       = push && !full;
  assign newpos    = (pos == '1) ? pos : pos + 1'b1;
  assign too_big   = 64'(newpos) > 64'(cfg.max_src);
  assign hdr_word  = {file_byte, tag[31:8]};
  assign hdr_done  = (sbi == 2'd3);
  assign rem_dec   = (rem == '0) ? '0 : rem - 32'd1;
  assign gather_new = gather | ({24'd0, file_byte} << {sbi, 3'b000});
  assign smp_done  = (sbi >= last_idx);
  assign prod_lo   = 32'(f_rate * {14'd0, align_r});
  assign trial     = {div_r, div_q[31]};
  assign trial_ge  = trial >= {1'b0, align_r};
  assign status_go = eof_pend && (phase != wsp_pkg::PH_CHECK) && !q_full;

  // Next state of the parser and the header check sequencer.
  always_comb begin
    phase_next    = phase;
    chk_next      = chk;
    pos_next      = pos;
    rem_next      = rem;
    tag_next      = tag;
    riff_next     = riff;
    raw_next      = raw;
    seen_next     = seen;
    gather_next   = gather;
    sbi_next      = sbi;
    err_next      = err;
    frames_next   = frames;
    chunk_id_next = chunk_id;
    pad_next      = pad;
    fmt_cnt_next  = fmt_cnt;
    eof_pend_next = eof_pend;
    align_next    = align_r;
    div_q_next    = div_q;
    div_r_next    = div_r;
    div_cnt_next  = div_cnt;
    samp_next     = samp_r;
    if (acc) begin
      pos_next = newpos;
      if (end_of_file) begin
        eof_pend_next = 1'b1;
      end
      if (err == wsp_pkg::ST_OK && too_big) begin
        err_next   = wsp_pkg::ST_TOO_LARGE;
        phase_next = wsp_pkg::PH_DONE;
      end else if (err == wsp_pkg::ST_OK) begin
        unique case (phase)
          wsp_pkg::PH_RIFF: begin
            tag_next = hdr_word;
            sbi_next = sbi + 2'd1;
            if (hdr_done) begin
              if (hdr_word != wsp_pkg::TAG_RIFF) begin
                err_next   = wsp_pkg::ST_NOT_WAVE;
                phase_next = wsp_pkg::PH_DONE;
              end else begin
                phase_next = wsp_pkg::PH_RSIZE;
              end
            end
          end
          wsp_pkg::PH_RSIZE: begin
            tag_next = hdr_word;
            sbi_next = sbi + 2'd1;
            if (hdr_done) begin
              riff_next  = hdr_word;
              phase_next = wsp_pkg::PH_WAVE;
            end
          end
          wsp_pkg::PH_WAVE: begin
            tag_next = hdr_word;
            sbi_next = sbi + 2'd1;
            if (hdr_done) begin
              if (hdr_word != wsp_pkg::TAG_WAVE) begin
                err_next   = wsp_pkg::ST_NOT_WAVE;
                phase_next = wsp_pkg::PH_DONE;
              end else if (riff < 32'd4) begin
                err_next   = wsp_pkg::ST_MALFORMED;
                phase_next = wsp_pkg::PH_DONE;
              end else begin
                phase_next = wsp_pkg::PH_ID;
              end
            end
          end
          wsp_pkg::PH_ID: begin
            tag_next = hdr_word;
            sbi_next = sbi + 2'd1;
            if (hdr_done) begin
              chunk_id_next = hdr_word;
              phase_next    = wsp_pkg::PH_SIZE;
            end
          end
          wsp_pkg::PH_SIZE: begin
            tag_next = hdr_word;
            sbi_next = sbi + 2'd1;
            if (hdr_done) begin
              pad_next = hdr_word[0];
              if (chunk_id == wsp_pkg::TAG_FMT && !seen[0]) begin
                if (hdr_word < 32'd16) begin
                  err_next   = wsp_pkg::ST_MALFORMED;
                  phase_next = wsp_pkg::PH_DONE;
                end else begin
                  seen_next[0] = 1'b1;
                  fmt_cnt_next = '0;
                  rem_next     = hdr_word;
                  phase_next   = wsp_pkg::PH_FMT;
                end
              end else if (chunk_id == wsp_pkg::TAG_DATA && !seen[1]) begin
                seen_next[1] = 1'b1;
                if (!seen[0] || hdr_word == '0) begin
                  err_next   = wsp_pkg::ST_MALFORMED;
                  phase_next = wsp_pkg::PH_DONE;
                end else begin
                  rem_next   = hdr_word;
                  chk_next   = wsp_pkg::CK_LIMITS;
                  phase_next = wsp_pkg::PH_CHECK;
                end
              end else begin
                rem_next   = hdr_word;
                phase_next = (hdr_word == '0) ? wsp_pkg::PH_ID : wsp_pkg::PH_SKIP;
              end
            end
          end
          wsp_pkg::PH_FMT: begin
            if (!fmt_cnt[4]) begin
              raw_next     = {file_byte, raw[127:8]};
              fmt_cnt_next = fmt_cnt + 5'd1;
            end
            rem_next = rem_dec;
            if (rem_dec == '0) begin
              phase_next = pad ? wsp_pkg::PH_PAD : wsp_pkg::PH_ID;
            end
          end
          wsp_pkg::PH_DATA: begin
            if (smp_done) begin
              gather_next = '0;
              sbi_next    = '0;
            end else begin
              gather_next = gather_new;
              sbi_next    = sbi + 2'd1;
            end
            rem_next = rem_dec;
            if (rem_dec == '0) begin
              phase_next = pad ? wsp_pkg::PH_PAD : wsp_pkg::PH_ID;
            end
          end
          wsp_pkg::PH_SKIP: begin
            rem_next = rem_dec;
            if (rem_dec == '0) begin
              phase_next = pad ? wsp_pkg::PH_PAD : wsp_pkg::PH_ID;
            end
          end
          wsp_pkg::PH_PAD: begin
            phase_next = wsp_pkg::PH_ID;
          end
          default: begin
          end
        endcase
      end
    end else if (phase == wsp_pkg::PH_CHECK) begin
      unique case (chk)
        wsp_pkg::CK_LIMITS: begin
          if (f_ch == '0 || f_ch > cfg.max_ch) begin
            err_next   = wsp_pkg::ST_CHANNELS;
            phase_next = wsp_pkg::PH_DONE;
          end else if (f_rate < cfg.min_rate || f_rate > cfg.max_rate) begin
            err_next   = wsp_pkg::ST_RATE;
            phase_next = wsp_pkg::PH_DONE;
          end else if (!enc_ok) begin
            err_next   = wsp_pkg::ST_ENCODING;
            phase_next = wsp_pkg::PH_DONE;
          end else begin
            align_next = 18'({2'd0, f_ch} * {15'd0, bps});
            chk_next   = wsp_pkg::CK_RATE;
          end
        end
        wsp_pkg::CK_RATE: begin
          if ({2'd0, f_align} != align_r || f_brate != prod_lo) begin
            err_next   = wsp_pkg::ST_MALFORMED;
            phase_next = wsp_pkg::PH_DONE;
          end else begin
            div_q_next   = rem;
            div_r_next   = '0;
            div_cnt_next = '0;
            chk_next     = wsp_pkg::CK_DIV;
          end
        end
        wsp_pkg::CK_DIV: begin
          div_r_next   = trial_ge ? 18'(trial - {1'b0, align_r}) : trial[17:0];
          div_q_next   = {div_q[30:0], trial_ge};
          div_cnt_next = div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            chk_next = wsp_pkg::CK_FRAMES;
          end
        end
        wsp_pkg::CK_FRAMES: begin
          if (div_r != '0) begin
            err_next   = wsp_pkg::ST_MALFORMED;
            phase_next = wsp_pkg::PH_DONE;
          end else if (div_q == '0 || div_q > cfg.max_frames) begin
            err_next   = wsp_pkg::ST_FRAMES;
            phase_next = wsp_pkg::PH_DONE;
          end else begin
            samp_next = 48'({16'd0, div_q} * {32'd0, f_ch});
            chk_next  = wsp_pkg::CK_BUDGET;
          end
        end
        wsp_pkg::CK_BUDGET: begin
          if ({samp_r, 2'b00} > {15'd0, cfg.max_dec}) begin
            err_next   = wsp_pkg::ST_DECODED;
            phase_next = wsp_pkg::PH_DONE;
          end else begin
            frames_next = div_q;
            sbi_next    = '0;
            gather_next = '0;
            phase_next  = wsp_pkg::PH_DATA;
          end
        end
        default: begin
        end
      endcase
    end else if (status_go) begin
      pos_next      = '0;
      phase_next    = wsp_pkg::PH_RIFF;
      rem_next      = '0;
      tag_next      = '0;
      riff_next     = '0;
      seen_next     = '0;
      gather_next   = '0;
      sbi_next      = '0;
      err_next      = wsp_pkg::ST_OK;
      frames_next   = '0;
      chunk_id_next = '0;
      pad_next      = 1'b0;
      fmt_cnt_next  = '0;
      eof_pend_next = 1'b0;
    end
  end

  // Final status of a file, taken from the state the last byte left.
  always_comb begin
    if (err != wsp_pkg::ST_OK) begin
      fin_code = err;
    end else if (phase == wsp_pkg::PH_RIFF || phase == wsp_pkg::PH_RSIZE ||
                 phase == wsp_pkg::PH_WAVE) begin
      fin_code = wsp_pkg::ST_MALFORMED;
    end else if ((64'(riff) + 64'd8) > 64'(pos)) begin
      fin_code = wsp_pkg::ST_MALFORMED;
    end else if (phase == wsp_pkg::PH_FMT || phase == wsp_pkg::PH_DATA ||
                 phase == wsp_pkg::PH_SKIP || phase == wsp_pkg::PH_PAD) begin
      fin_code = wsp_pkg::ST_MALFORMED;
    end else if (!seen[1]) begin
      fin_code = wsp_pkg::ST_MALFORMED;
    end else begin
      fin_code = wsp_pkg::ST_OK;
    end
  end

  always_comb begin
    q_push = 1'b0;
    q_data = '{is_status: 1'b0, kind: kind, data: gather_new, code: wsp_pkg::ST_OK};
    if (status_go) begin
      q_push = 1'b1;
      q_data = '{is_status: 1'b1, kind: kind,
                 data: (fin_code == wsp_pkg::ST_OK) ? frames : '0,
                 code: fin_code};
    end else if (acc && err == wsp_pkg::ST_OK && !too_big &&
                 phase == wsp_pkg::PH_DATA && smp_done) begin
      q_push = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= wsp_pkg::PH_RIFF;
      chk      <= wsp_pkg::CK_LIMITS;
      pos      <= '0;
      rem      <= '0;
      tag      <= '0;
      riff     <= '0;
      seen     <= '0;
      gather   <= '0;
      sbi      <= '0;
      err      <= wsp_pkg::ST_OK;
      frames   <= '0;
      chunk_id <= '0;
      pad      <= 1'b0;
      fmt_cnt  <= '0;
      eof_pend <= 1'b0;
    end else begin
      phase    <= phase_next;
      chk      <= chk_next;
      pos      <= pos_next;
      rem      <= rem_next;
      tag      <= tag_next;
      riff     <= riff_next;
      seen     <= seen_next;
      gather   <= gather_next;
      sbi      <= sbi_next;
      err      <= err_next;
      frames   <= frames_next;
      chunk_id <= chunk_id_next;
      pad      <= pad_next;
      fmt_cnt  <= fmt_cnt_next;
      eof_pend <= eof_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    raw     <= raw_next;
    align_r <= align_next;
    div_q   <= div_q_next;
    div_r   <= div_r_next;
    div_cnt <= div_cnt_next;
    samp_r  <= samp_next;
  end

endmodule

/* hdl/wsp_back.sv */
// ----------------------------------------------------------------------------
// wsp_back
// Two-stage converter from raw sample words to float32, with output register.
// ----------------------------------------------------------------------------
module wsp_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  output logic              q_pop,
  input  wsp_pkg::q_entry_t q_data,
  output logic              empty,
  input  logic              pop,
  output logic              is_status,
  output logic [31:0]       sample_bits,
  output logic [3:0]        status_code,
  output logic [31:0]       frame_total,
  output logic              final_item
);

  logic s1_v, s2_v, s1_load, s2_load;

  // Stage one results.
  logic [31:0] v, mag, fword;
  logic [4:0]  lz;
  logic [4:0]  scale;
  logic        is_int;

  logic        s1_status, s1_sign, s1_int;
  logic [31:0] s1_mag, s1_word;
  logic [4:0]  s1_lz, s1_scale;
  logic [3:0]  s1_code;

  // Stage two results.
  logic [31:0] norm;
  logic        rnd;
  logic [24:0] mant;
  logic [8:0]  exp9;
  logic [31:0] conv;

  assign s2_load = s1_v && (!s2_v || pop);
  assign s1_load = !q_empty && (!s1_v || s2_load);
  assign q_pop   = s1_load;
  assign empty   = !s2_v;

  always_comb begin
    is_int = 1'b1;
    case (q_data.kind)
      wsp_pkg::SK_U8: begin
        v     = {24'd0, q_data.data[7:0]} - 32'd128;
        scale = 5'd7;
      end
      wsp_pkg::SK_S16: begin
        v     = {{16{q_data.data[15]}}, q_data.data[15:0]};
        scale = 5'd15;
      end
      wsp_pkg::SK_S24: begin
        v     = {{8{q_data.data[23]}}, q_data.data[23:0]};
        scale = 5'd23;
      end
      wsp_pkg::SK_S32: begin
        v     = q_data.data;
        scale = 5'd31;
      end
      default: begin
        v      = q_data.data;
        scale  = 5'd31;
        is_int = 1'b0;
      end
    endcase
  end

  assign mag = v[31] ? (~v + 32'd1) : v;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) begin
        lz = 5'(31 - i);
      end
    end
  end

  // NaN and infinity become zero; anything larger than one is clamped.
  always_comb begin
    if (q_data.data[30:23] == 8'hFF) begin
      fword = '0;
    end else if (q_data.data[30:0] > 31'h3F80_0000) begin
      fword = {q_data.data[31], 31'h3F80_0000};
    end else begin
      fword = q_data.data;
    end
  end

  assign norm = s1_mag << s1_lz;
  assign rnd  = norm[7] && ((|norm[6:0]) || norm[8]);
  assign mant = {1'b0, norm[31:8]} + {24'd0, rnd};
  assign exp9 = 9'd158 - {4'd0, s1_lz} - {4'd0, s1_scale} + {8'd0, mant[24]};
  assign conv = (s1_mag == '0) ? '0 :
                {s1_sign, exp9[7:0], mant[24] ? 23'd0 : mant[22:0]};

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_status <= q_data.is_status;
      s1_sign   <= v[31];
      s1_int    <= is_int && !q_data.is_status;
      s1_mag    <= mag;
      s1_lz     <= lz;
      s1_scale  <= scale;
      s1_word   <= q_data.is_status ? q_data.data : fword;
      s1_code   <= q_data.code;
    end
    if (s2_load) begin
      is_status   <= s1_status;
      final_item  <= s1_status;
      status_code <= s1_status ? s1_code : wsp_pkg::ST_OK;
      frame_total <= s1_status ? s1_word : '0;
      sample_bits <= s1_status ? '0 : (s1_int ? conv : s1_word);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v <= 1'b1;
      end else if (s2_load) begin
        s1_v <= 1'b0;
      end
      if (s2_load) begin
        s2_v <= 1'b1;
      end else if (pop) begin
        s2_v <= 1'b0;
      end
    end
  end

endmodule

/* tb/wave_stream_parser_pcm_to_float_test.sv */
// ----------------------------------------------------------------------------
// WAVE stream parser testbench
// Pushes whole RIFF/WAVE files, well formed and broken, through the parser one
// byte per transfer. An own model of the parser predicts every float32 sample
// and the status of each file, and each popped result is checked against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wave_stream_parser_pcm_to_float_test;

  // One decoded result, either a sample or the status that closes a file.
  typedef struct packed {
    bit        st;
    bit [31:0] smp;
    bit [3:0]  code;
    bit [31:0] frames;
    bit        fin;
  } wave_result_t;

  // The scoreboard carries its own copy of the parser state and of the limit
  // registers, and keeps the predicted results in arrival order.
  class wave_scoreboard;
    wave_result_t pending_q[$];
    int unsigned  mismatches, n_samples, n_status, n_ok;

    bit [31:0] lim_src, lim_rate_lo, lim_rate_hi, lim_frames;
    bit [15:0] lim_ch;
    bit [34:0] lim_dec;

    bit [wsp_pkg::POS_W-1:0] pos;
    wsp_pkg::phase_t         phase;
    bit [32:0]      remain;
    bit [31:0]      shift_w, riff_size, rate, fmt_brate, gather, frames_out, cid;
    bit [15:0]      enc, chans, align, bits;
    bit [1:0]       seen, idx;
    bit [3:0]       err;
    bit             pad;
    int unsigned    fmt_n;
    bit [7:0]       raw [16];

    function new();
      lim_src = 32'd16777216; lim_ch = 16'd2; lim_rate_lo = 32'd8000;
      lim_rate_hi = 32'd192000; lim_frames = 32'd4194304; lim_dec = 35'd33554432;
      clear();
    endfunction

    function void set_limit(logic [2:0] index, logic [34:0] value);
      case (index)
        wsp_pkg::CFG_MAX_SRC:    lim_src = value[31:0];
        wsp_pkg::CFG_MAX_CH:     lim_ch = value[15:0];
        wsp_pkg::CFG_MIN_RATE:   lim_rate_lo = value[31:0];
        wsp_pkg::CFG_MAX_RATE:   lim_rate_hi = value[31:0];
        wsp_pkg::CFG_MAX_FRAMES: lim_frames = value[31:0];
        wsp_pkg::CFG_MAX_DEC:    lim_dec = value;
        default: ;
      endcase
    endfunction

    function void clear();
      pos = '0; phase = wsp_pkg::PH_RIFF; remain = '0; shift_w = '0; riff_size = '0;
      enc = '0; chans = '0; rate = '0; fmt_brate = '0; align = '0; bits = '0;
      seen = '0; gather = '0; idx = '0; err = wsp_pkg::ST_OK; frames_out = '0;
      cid = '0; pad = 0; fmt_n = 0;
      foreach (raw[i]) raw[i] = '0;
    endfunction

    function void fail(bit [3:0] code);
      err = code;
      phase = wsp_pkg::PH_DONE;
    endfunction

    // Signed integer v divided by 2^e, rounded to the nearest float32.
    function bit [31:0] int_to_f32(longint v, int e);
      bit                s;
      longint unsigned   m, mant, rem, half;
      int                p, sh;
      if (v == 0) return 32'd0;
      s = v < 0;
      m = s ? -v : v;
      p = 63;
      while (!m[p]) p--;
      if (p <= 23) begin
        mant = m << (23 - p);
      end else begin
        sh = p - 23;
        mant = m >> sh;
        rem = m & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && mant[0])) mant++;
        if (mant == (64'd1 << 24)) begin
          mant >>= 1;
          p++;
        end
      end
      return {s, 8'(p - e + 127), mant[22:0]};
    endfunction

    function bit [31:0] decode(bit [31:0] w);
      if (enc == wsp_pkg::ENC_FLOAT) begin
        // Infinities and NaNs become zero, anything past unity is clamped.
        if (w[30:23] == 8'hFF) return 32'd0;
        if (w[30:0] > 31'h3F80_0000) return {w[31], 31'h3F80_0000};
        return w;
      end
      case (bits)
        16'd8:  return int_to_f32(longint'(w[7:0]) - 128, 7);
        16'd16: return int_to_f32(longint'($signed(w[15:0])), 15);
        16'd24: return int_to_f32(longint'($signed(w[23:0])), 23);
        16'd32: return int_to_f32(longint'($signed(w)), 31);
        default: return 32'd0;
      endcase
    endfunction

    function bit header_byte(bit [7:0] b);
      shift_w = {b, shift_w[31:8]};
      idx = idx + 2'd1;
      return idx == 2'd0;
    endfunction

    function void end_payload();
      phase = pad ? wsp_pkg::PH_PAD : wsp_pkg::PH_ID;
    endfunction

    function void start_data(bit [31:0] size);
      bit [31:0]       bps, al, nfr;
      longint unsigned nsmp;
      if (!seen[0] || size == 0) begin fail(wsp_pkg::ST_MALFORMED); return; end
      if (chans == 0 || chans > lim_ch) begin fail(wsp_pkg::ST_CHANNELS); return; end
      if (rate < lim_rate_lo || rate > lim_rate_hi) begin fail(wsp_pkg::ST_RATE); return; end
      if (!((enc == wsp_pkg::ENC_PCM && bits inside {16'd8, 16'd16, 16'd24, 16'd32}) ||
            (enc == wsp_pkg::ENC_FLOAT && bits == 16'd32))) begin
        fail(wsp_pkg::ST_ENCODING);
        return;
      end
      bps = bits / 8;
      al = chans * bps;
      if (32'(align) != al || fmt_brate != 32'(rate * al) || size % al != 0) begin
        fail(wsp_pkg::ST_MALFORMED);
        return;
      end
      nfr = size / al;
      if (nfr == 0 || nfr > lim_frames) begin fail(wsp_pkg::ST_FRAMES); return; end
      nsmp = longint'(nfr) * chans;
      if (nsmp * 4 > lim_dec) begin fail(wsp_pkg::ST_DECODED); return; end
      frames_out = nfr;
      remain = size;
      idx = '0;
      gather = '0;
      phase = wsp_pkg::PH_DATA;
    endfunction

    function void start_chunk(bit [31:0] size);
      pad = size[0];
      if (cid == wsp_pkg::TAG_FMT && !seen[0]) begin
        if (size < 16) begin fail(wsp_pkg::ST_MALFORMED); return; end
        seen[0] = 1;
        fmt_n = 0;
        remain = size;
        phase = wsp_pkg::PH_FMT;
      end else if (cid == wsp_pkg::TAG_DATA && !seen[1]) begin
        seen[1] = 1;
        start_data(size);
      end else begin
        remain = size;
        if (size == 0) end_payload();
        else phase = wsp_pkg::PH_SKIP;
      end
    endfunction

    function void count_down();
      if (remain > 0) remain--;
      if (remain == 0) end_payload();
    endfunction

    // Notes one accepted byte and queues whatever results it brings.
    function void note_byte(bit [7:0] b, bit eof);
      bit [wsp_pkg::POS_W-1:0] newpos;
      bit [1:0]       last;
      wave_result_t   r;
      newpos = (pos == '1) ? pos : pos + 1'b1;
      if (err == wsp_pkg::ST_OK && newpos > lim_src) begin
        fail(wsp_pkg::ST_TOO_LARGE);
      end else if (err == wsp_pkg::ST_OK) begin
        case (phase)
          wsp_pkg::PH_RIFF:
            if (header_byte(b)) begin
              if (shift_w != wsp_pkg::TAG_RIFF) fail(wsp_pkg::ST_NOT_WAVE);
              else phase = wsp_pkg::PH_RSIZE;
            end
          wsp_pkg::PH_RSIZE:
            if (header_byte(b)) begin
              riff_size = shift_w;
              phase = wsp_pkg::PH_WAVE;
            end
          wsp_pkg::PH_WAVE:
            if (header_byte(b)) begin
              if (shift_w != wsp_pkg::TAG_WAVE) fail(wsp_pkg::ST_NOT_WAVE);
              else if (riff_size < 4) fail(wsp_pkg::ST_MALFORMED);
              else phase = wsp_pkg::PH_ID;
            end
          wsp_pkg::PH_ID:
            if (header_byte(b)) begin
              cid = shift_w;
              phase = wsp_pkg::PH_SIZE;
            end
          wsp_pkg::PH_SIZE:
            if (header_byte(b)) start_chunk(shift_w);
          wsp_pkg::PH_FMT: begin
            if (fmt_n < 16) begin
              raw[fmt_n] = b;
              fmt_n++;
              if (fmt_n == 16) begin
                enc = {raw[1], raw[0]};
                chans = {raw[3], raw[2]};
                rate = {raw[7], raw[6], raw[5], raw[4]};
                fmt_brate = {raw[11], raw[10], raw[9], raw[8]};
                align = {raw[13], raw[12]};
                bits = {raw[15], raw[14]};
              end
            end
            count_down();
          end
          wsp_pkg::PH_DATA: begin
            last = 2'((bits / 8) - 1);
            gather |= 32'(b) << (8 * idx);
            if (idx >= last) begin
              r = '{0, decode(gather), wsp_pkg::ST_OK, 0, 0};
              pending_q.push_back(r);
              gather = '0;
              idx = '0;
            end else begin
              idx = idx + 2'd1;
            end
            count_down();
          end
          wsp_pkg::PH_SKIP: count_down();
          wsp_pkg::PH_PAD:  phase = wsp_pkg::PH_ID;
          default: ;
        endcase
      end
      pos = newpos;

      if (eof) begin
        if (err == wsp_pkg::ST_OK) begin
          if (phase <= wsp_pkg::PH_WAVE) fail(wsp_pkg::ST_MALFORMED);
          else if (64'(riff_size) + 64'd8 > 64'(pos)) fail(wsp_pkg::ST_MALFORMED);
          else if (phase >= wsp_pkg::PH_FMT && phase <= wsp_pkg::PH_PAD)
            fail(wsp_pkg::ST_MALFORMED);
          else if (!seen[1]) fail(wsp_pkg::ST_MALFORMED);
        end
        r = '{1, 0, err, (err == wsp_pkg::ST_OK) ? frames_out : 32'd0, 1};
        pending_q.push_back(r);
        clear();
      end
    endfunction

    // Compares one popped result with the oldest prediction.
    function void check_result(wave_result_t got);
      wave_result_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result st=%0d smp=%h code=%0d frames=%0d fin=%0d",
                   $realtime, got.st, got.smp, got.code, got.frames, got.fin);
        return;
      end
      want = pending_q.pop_front();
      if (got.st) begin
        n_status++;
        if (got.code == wsp_pkg::ST_OK) n_ok++;
      end else begin
        n_samples++;
      end
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch, expected st=%0d smp=%h code=%0d frames=%0d fin=%0d,",
                    " got st=%0d smp=%h code=%0d frames=%0d fin=%0d"}, $realtime,
                   want.st, want.smp, want.code, want.frames, want.fin,
                   got.st, got.smp, got.code, got.frames, got.fin);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        push = 0;
  logic        full;
  logic [7:0]  file_byte = '0;
  logic        end_of_file = 0;
  logic        empty;
  logic        pop = 0;
  logic        is_status;
  logic [31:0] sample_bits;
  logic [3:0]  status_code;
  logic [31:0] frame_total;
  logic        final_item;
  logic        cfg_wr_en = 0;
  logic [2:0]  cfg_index = '0;
  logic [34:0] cfg_data = '0;

  wave_scoreboard wave_sb;
  logic [7:0]     file_q[$];
  bit             tx_gaps = 1, rx_stalls = 1;
  int unsigned    n_files, n_bytes;

  localparam logic [31:0] TAG_LIST = 32'h5453_494C;

  wave_stream_parser_pcm_to_float dut (.*);

  always #10 clk = ~clk;

  // Hard stop in case the parser hangs.
  initial begin
    #5ms;
    $display("[wave_stream_parser_pcm_to_float] ERROR");
    $finish;
  end

  // Result side: accept at the rising edge, decide the next pop at the falling
  // edge. Stalls come in bursts so that they land on every part of a file.
  initial begin
    int stall;
    wave_result_t got;
    stall = 0;
    forever begin
      @(posedge clk);
      if (pop && !empty && !rst) begin
        got = '{is_status, sample_bits, status_code, frame_total, final_item};
        wave_sb.check_result(got);
      end
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        pop = 0;
      end else if (rx_stalls && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 8) - 1;
        pop = 0;
      end else begin
        pop = 1;
      end
    end
  end

  task automatic put8(logic [7:0] b);
    file_q.push_back(b);
  endtask

  task automatic put16(logic [15:0] v);
    put8(v[7:0]);
    put8(v[15:8]);
  endtask

  task automatic put32(logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endtask

  // Sample bytes lean on the extremes of the integer codes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // Float words: ordinary values in range, exactly one, past unity, infinities, NaNs, zero, random words.
  function automatic logic [31:0] pick_float();
    case ($urandom_range(0, 7))
      0: return {1'($urandom), 8'hFF, 23'($urandom_range(0, 1) ? 0 : $urandom)};
      1: return {1'($urandom), 8'($urandom_range(127, 254)), 23'($urandom)};
      2: return {1'($urandom), 31'h3F80_0000};
      3: return {1'($urandom), 31'h0};
      4: return $urandom;
      default: return {1'($urandom), 8'($urandom_range(0, 126)), 23'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 7))
      0: return 32'd8000;
      1: return 32'd44100;
      2: return 32'd48000;
      3: return 32'd192000;
      4: return 32'd7999;
      5: return 32'd192001;
      6: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  // A chunk the parser has to skip, with a pad byte when its size is odd.
  task automatic put_skip_chunk();
    int sz;
    sz = $urandom_range(0, 5);
    put32(TAG_LIST);
    put32(sz);
    repeat (sz) put8($urandom);
    if (sz % 2) put8(8'h00);
  endtask

  task automatic put_fmt(int fsz, logic [15:0] enc, logic [15:0] ch, logic [31:0] rate,
                         logic [31:0] brate, logic [15:0] al, logic [15:0] bits);
    put32(wsp_pkg::TAG_FMT);
    put32(fsz);
    if (fsz < 16) begin
      repeat (fsz) put8($urandom);
    end else begin
      put16(enc); put16(ch); put32(rate); put32(brate); put16(al); put16(bits);
      repeat (fsz - 16) put8($urandom);
    end
    if (fsz % 2) put8(8'h00);
  endtask

  // Builds one random file into file_q. Many files are well formed with random
  // formats and content; the rest carry one or more of the ways to break a file.
  task automatic gen_file();
    int          kind, sel, ch, bits, bpf, al, frames, dsize, fsz, cut;
    logic [15:0] enc;
    logic [31:0] rate, brate, w, rsz;
    bit          fmt_first;
    file_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 5) begin
      // Noise, sometimes with a proper start, often shorter than a header.
      if ($urandom_range(0, 1)) put32(wsp_pkg::TAG_RIFF);
      repeat ($urandom_range(1, 20)) put8($urandom);
      return;
    end
    sel = $urandom_range(0, 11);
    enc = wsp_pkg::ENC_PCM;
    case (sel)
      0, 1:    bits = 8;
      2, 3:    bits = 16;
      4:       bits = 24;
      5, 6:    bits = 32;
      7, 8, 9: begin enc = wsp_pkg::ENC_FLOAT; bits = 32; end
      10:      bits = 12;
      default: begin enc = $urandom_range(0, 1) ? wsp_pkg::ENC_FLOAT : 16'd2; bits = 16; end
    endcase
    case ($urandom_range(0, 19))
      0: ch = 0;
      1: ch = 3;
      default: ch = $urandom_range(1, 2);
    endcase
    rate = pick_rate();
    bpf = ch * bits / 8;
    al = bpf;
    if ($urandom_range(0, 11) == 0) al++;
    brate = 32'(rate * al);
    if ($urandom_range(0, 11) == 0) brate ^= 32'd1 << $urandom_range(0, 31);
    frames = $urandom_range(1, (bpf == 0) ? 4 : ((24 / bpf) > 1 ? 24 / bpf : 1));
    dsize = (bpf == 0) ? 4 : frames * bpf;
    case ($urandom_range(0, 14))
      0: dsize = 0;
      1: dsize++;
      default: ;
    endcase
    fsz = 16;
    case ($urandom_range(0, 19))
      0, 1: fsz = 18;
      2:    fsz = $urandom_range(0, 15);
      default: ;
    endcase
    fmt_first = $urandom_range(0, 14) != 0;

    put32(wsp_pkg::TAG_RIFF);
    put32(0);
    put32(wsp_pkg::TAG_WAVE);
    if ($urandom_range(0, 3) == 0) put_skip_chunk();
    if (fmt_first) put_fmt(fsz, enc, ch, rate, brate, al, bits);
    if ($urandom_range(0, 4) == 0) put_skip_chunk();
    put32(wsp_pkg::TAG_DATA);
    put32(dsize);
    for (int i = 0; i < dsize; i++) begin
      if (enc == wsp_pkg::ENC_FLOAT) begin
        if (i % 4 == 0) w = pick_float();
        put8(w[8 * (i % 4) +: 8]);
      end else begin
        put8(pick_byte());
      end
    end
    if (dsize % 2) put8(8'h00);
    if (!fmt_first) put_fmt(fsz, enc, ch, rate, brate, al, bits);
    case ($urandom_range(0, 9))
      0: put_skip_chunk();
      1: put_fmt(16, enc, ch, rate, brate, al, bits);
      2: begin put32(wsp_pkg::TAG_DATA); put32(2); put16($urandom); end
      default: ;
    endcase

    // Declared size: usually exact, sometimes past the end, short of it or below four.
    rsz = file_q.size() - 8;
    case ($urandom_range(0, 19))
      0, 1: rsz += $urandom_range(1, 9);
      2:    rsz = $urandom_range(0, 3);
      3:    rsz -= $urandom_range(1, 4);
      default: ;
    endcase
    for (int i = 0; i < 4; i++) file_q[4 + i] = rsz[8 * i +: 8];

    case ($urandom_range(0, 24))
      0: file_q[$urandom_range(0, 3)] ^= 8'd1 << $urandom_range(0, 7);
      1: file_q[$urandom_range(8, 11)] ^= 8'd1 << $urandom_range(0, 7);
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: begin
        // Truncated somewhere inside the file.
        cut = $urandom_range(1, file_q.size() - 1);
        repeat (cut) void'(file_q.pop_back());
      end
      1: repeat ($urandom_range(1, 3)) put8($urandom);
      default: ;
    endcase
  endtask

  // One byte transfer, with an occasional burst of idle cycles before it.
  task automatic send_byte(logic [7:0] b, logic eof);
    @(negedge clk);
    if (tx_gaps && $urandom_range(0, 11) == 0) begin
      push = 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    push = 1;
    file_byte = b;
    end_of_file = eof;
    do @(posedge clk); while (full);
    wave_sb.note_byte(b, eof);
    n_bytes++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    @(negedge clk);
    push = 0;
    end_of_file = 0;
    n_files++;
  endtask

  // Waits until every predicted result has been popped, then lets the format
  // check of the parser run out before anything is changed.
  task automatic wait_idle();
    while (wave_sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_limit(logic [2:0] index, logic [34:0] value);
    @(negedge clk);
    cfg_wr_en = 1;
    cfg_index = index;
    cfg_data = value;
    @(negedge clk);
    cfg_wr_en = 0;
    wave_sb.set_limit(index, value);
  endtask

  task automatic write_limits(logic [31:0] src, logic [15:0] ch, logic [31:0] rlo,
                              logic [31:0] rhi, logic [31:0] frm, logic [34:0] dec);
    write_limit(wsp_pkg::CFG_MAX_SRC, src);
    write_limit(wsp_pkg::CFG_MAX_CH, ch);
    write_limit(wsp_pkg::CFG_MIN_RATE, rlo);
    write_limit(wsp_pkg::CFG_MAX_RATE, rhi);
    write_limit(wsp_pkg::CFG_MAX_FRAMES, frm);
    write_limit(wsp_pkg::CFG_MAX_DEC, dec);
  endtask

  initial begin
    wave_sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed files under the reset limits. A file of three bytes is too
    // short to hold a header.
    file_q = '{8'h52, 8'h49, 8'h46};
    send_file();
    // A wrong first tag.
    file_q.delete();
    put32(32'h4646_4953); put32(4); put32(wsp_pkg::TAG_WAVE);
    send_file();
    // Mono float32 with an infinity, a NaN, values past unity and a half.
    file_q.delete();
    put32(wsp_pkg::TAG_RIFF); put32(56); put32(wsp_pkg::TAG_WAVE);
    put_fmt(16, wsp_pkg::ENC_FLOAT, 1, 48000, 192000, 4, 32);
    put32(wsp_pkg::TAG_DATA); put32(20);
    put32(32'h7F80_0000); put32(32'hFFC0_0001); put32(32'h4000_0000);
    put32(32'hC040_0000); put32(32'h3F00_0000);
    send_file();
    // Stereo PCM16 at the integer extremes.
    file_q.delete();
    put32(wsp_pkg::TAG_RIFF); put32(44); put32(wsp_pkg::TAG_WAVE);
    put_fmt(16, wsp_pkg::ENC_PCM, 2, 44100, 176400, 4, 16);
    put32(wsp_pkg::TAG_DATA); put32(8);
    put16(16'h8000); put16(16'h7FFF); put16(16'h0000); put16(16'hFFFF);
    send_file();

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) wait_idle();
      case (ph)
        1: write_limits(32'hFFFF_FFFF, 16'hFFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        35'h4_0000_0000);
        2: write_limits($urandom_range(12, 120), 16'd1, 32'd44100, 32'd48000,
                        $urandom_range(1, 4), $urandom_range(0, 40));
        3: write_limits($urandom_range(40, 200), $urandom_range(1, 3),
                        $urandom_range(0, 8000), $urandom_range(44100, 200000),
                        $urandom_range(1, 12), $urandom_range(8, 120));
        4: begin
          // Back to the reset values, and from here on no idling at all.
          write_limits(32'd16777216, 16'd2, 32'd8000, 32'd192000, 32'd4194304,
                       35'd33554432);
          tx_gaps = 0;
          rx_stalls = 0;
        end
        default: ;
      endcase
      while (n_bytes < 260 * (ph + 1)) begin
        gen_file();
        send_file();
        // Let the output side drain completely once before going on.
        if (ph == 1 && n_files % 7 == 0) wait_idle();
      end
    end

    while (wave_sb.pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d files in %0d bytes; checked %0d samples and %0d statuses (%0d ok).",
             n_files, n_bytes, wave_sb.n_samples, wave_sb.n_status, wave_sb.n_ok);
    if (wave_sb.mismatches == 0 && wave_sb.pending_q.size() == 0) begin
      $display("[wave_stream_parser_pcm_to_float] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", wave_sb.mismatches,
               wave_sb.pending_q.size());
      $display("[wave_stream_parser_pcm_to_float] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/wsp_pkg.sv
hdl/wsp_queue.sv
hdl/wsp_front.sv
hdl/wsp_back.sv
hdl/wave_stream_parser_pcm_to_float.sv
tb/wave_stream_parser_pcm_to_float_test.sv
